FILE: rtl/core/bpp_pkg.sv
// bpp_pkg: shared constants and types of the Bezier particle pool.
// Used by bezier_particle_pool and bpp_free; has no dependencies.
package bpp_pkg;

  localparam int PARTICLES_DEF  = 256;
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int OFF_BITS      = 15;  // control point offset width
  localparam int SLOT_BITS     = 8;
  localparam int DUR_BITS      = 8;
  localparam int CUBE_BITS     = 3 * DUR_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int SCAN_CHUNK    = 16;  // active bits searched per cycle
  localparam int SCAN_POS_BITS = 4;
  localparam int C2_DX         = 10;  // second control point offset, whole units
  localparam int C2_DY         = 50;
  localparam int C2_BITS       = 7;

  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_END_X = 2'd0,
    CFG_END_Y = 2'd1,
    CFG_END_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic scan;
    logic set;
    logic clr;
  } free_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } free_stat_t;

endpackage

FILE: rtl/core/bezier_particle_pool.sv
// Pool of particles moving on cubic Bezier curves toward a shared end point.
// Input channel (in_valid_i / in_stall_o): kind_i selects spawn or tick; one
// item is worked at a time and in_stall_o is high until it is finished.
// Output channel (out_valid_o / out_stall_i): exactly one result item per input
// item. The result register holds while out_stall_i is high, and the next input
// item is already taken meanwhile; it waits at the end for the register.
// Spawn: the active flags are searched 16 slots per cycle, from slot 0 upward.
// Tick: slot record read from the state RAM, then powers and products in ST_POW1,
// ST_POW2, ST_PROD and ST_SUM, ST_DIV to start the dividers, then a restoring
// divider giving one quotient bit per cycle over the numerator width (52 bits at
// the defaults); the divider sets the rate.
// A tick on a free slot goes straight to the result; a full pool costs a whole search.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes the end point; the user must
// write it only while idle; the block does not enforce it. Reset frees every slot and
// clears the end point; no clearing pass is needed, the slot RAM is only read for
// active slots. Depends on bpp_pkg, bpp_ram, bpp_div, bpp_free.
module bezier_particle_pool #(
  parameter int PARTICLES  = bpp_pkg::PARTICLES_DEF,
  parameter int COORD_BITS = bpp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bpp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpp_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [COORD_BITS-1:0]               cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [bpp_pkg::SLOT_BITS-1:0]       slot_i,
  input  logic signed [COORD_BITS-1:0]        start_x_i,
  input  logic signed [COORD_BITS-1:0]        start_y_i,
  input  logic signed [COORD_BITS-1:0]        start_z_i,
  input  logic [bpp_pkg::OFF_BITS-1:0]        ctrl_dx_i,
  input  logic [bpp_pkg::OFF_BITS-1:0]        ctrl_dy_i,
  input  logic [bpp_pkg::DUR_BITS-1:0]        duration_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bpp_pkg::SLOT_BITS-1:0]       out_slot_o,
  output logic                                ok_o,
  output logic signed [COORD_BITS-1:0]        pos_x_o,
  output logic signed [COORD_BITS-1:0]        pos_y_o,
  output logic signed [COORD_BITS-1:0]        pos_z_o,
  output logic                                retired_o
);

  localparam int CB  = COORD_BITS;
  localparam int OB  = bpp_pkg::OFF_BITS;
  localparam int DB  = bpp_pkg::DUR_BITS;
  localparam int QB  = bpp_pkg::CUBE_BITS;
  localparam int SB  = bpp_pkg::SLOT_BITS;
  localparam int SW  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int KW  = bpp_pkg::C2_BITS + FRAC_BITS;
  localparam int P1W = CB + QB + 2;
  localparam int P2W = OB + QB;
  localparam int P3W = KW + QB;
  localparam int NWA = (P1W > P3W + 2) ? P1W : (P3W + 2);
  localparam int NWB = (NWA > P2W + 2) ? NWA : (P2W + 2);
  localparam int NW  = NWB + 2;
  localparam int RW  = 3 * CB + 2 * OB + 2 * DB;
  localparam logic [KW-1:0] K2X = KW'(bpp_pkg::C2_DX) << FRAC_BITS;
  localparam logic [KW-1:0] K2Y = KW'(bpp_pkg::C2_DY) << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_LOAD, ST_POW1, ST_POW2, ST_PROD, ST_SUM, ST_DIV,
    ST_WAIT, ST_OUT
  } state_e;

  state_e state_q;

  logic signed [CB-1:0] end_x_q, end_y_q, end_z_q;

  logic                  in_acc, tick_ok, div_done, retire;
  logic                  dvy, dvz;
  logic [SW-1:0]         slot_idx, free_idx, free_sel;
  logic                  slot_active;
  bpp_pkg::free_cmd_t    free_cmd;
  bpp_pkg::free_stat_t   free_stat;

  logic                  ram_we;
  logic [SW-1:0]         ram_addr;
  logic [RW-1:0]         ram_wdata, ram_rdata;

  // item working registers
  logic [SB-1:0]         slot_q;
  logic signed [CB-1:0]  sx_q, sy_q, sz_q;
  logic [OB-1:0]         dx_q, dy_q;
  logic [DB-1:0]         dur_q, c_q, d_q, u_q;
  logic [DB-1:0]         rd_cnt, rd_tot, c_new;
  logic signed [CB:0]    dfx_q, dfy_q, dfz_q;
  logic [2*DB-1:0]       c2_q, u2_q, d2_q;
  logic [QB-1:0]         c3_q, u2c_q, uc2_q, d3_q;
  logic signed [P1W-1:0] p1x_q, p1y_q, p1z_q;
  logic [P2W-1:0]        p2x_q, p2y_q;
  logic [P3W-1:0]        p3x_q, p3y_q;
  logic [NW-1:0]         numx_q, numy_q, numz_q;
  logic signed [NW-1:0]  qx, qy, qz;

  logic [SB-1:0]         res_slot_q;
  logic                  res_ok_q, res_ret_q;
  logic signed [CB-1:0]  res_x_q, res_y_q, res_z_q;

  function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] s,
                                                   input logic signed [NW-1:0] q);
    logic [NW:0]      sum;
    logic [NW-CB+1:0] hi;
    sum = {q[NW-1], q} + {{(NW + 1 - CB){s[CB-1]}}, s};
    hi  = sum[NW:CB-1];
    if (hi == '0 || hi == '1) begin
      sat_add = sum[CB-1:0];
    end else if (sum[NW]) begin
      sat_add = {1'b1, {(CB - 1){1'b0}}};
    end else begin
      sat_add = {1'b0, {(CB - 1){1'b1}}};
    end
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_idx   = SW'(slot_i);
  assign tick_ok    = (32'(slot_i) < PARTICLES) && slot_active;

  assign rd_tot = ram_rdata[2*DB-1:DB];
  assign rd_cnt = ram_rdata[DB-1:0];
  assign c_new  = (rd_cnt < rd_tot) ? (rd_cnt + 1'b1) : rd_cnt;
  assign retire = (c_q >= d_q);

  // ---------------- slot flags ----------------
  always_comb begin
    free_cmd.scan = (state_q == ST_IDLE) && in_acc && (kind_i == bpp_pkg::KIND_SPAWN);
    free_cmd.set  = (state_q == ST_SCAN) && free_stat.done && free_stat.found;
    free_cmd.clr  = (state_q == ST_WAIT) && div_done && retire;
    free_sel      = free_cmd.set ? free_idx : SW'(slot_q);
  end

  bpp_free #(
    .PARTICLES(PARTICLES),
    .SW       (SW)
  ) u_free (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (free_cmd),
    .idx_i     (free_sel),
    .look_i    (slot_idx),
    .active_o  (slot_active),
    .stat_o    (free_stat),
    .free_idx_o(free_idx)
  );

  // ---------------- slot record RAM ----------------
  // record: {sz, sy, sx, dy, dx, total, count}
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_idx;
    ram_wdata = {sz_q, sy_q, sx_q, dy_q, dx_q, d_q, c_q};
    case (state_q)
      ST_SCAN: begin
        ram_addr  = free_idx;
        ram_we    = free_stat.done && free_stat.found;
        ram_wdata = {sz_q, sy_q, sx_q, dy_q, dx_q, dur_q, {DB{1'b0}}};
      end
      ST_WAIT: begin
        ram_addr = SW'(slot_q);
        ram_we   = div_done;
      end
      default: begin
        ram_addr = slot_idx;
      end
    endcase
  end

  bpp_ram #(
    .WIDTH(RW),
    .DEPTH(PARTICLES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // ---------------- dividers, one per axis ----------------
  bpp_div #(.NW(NW), .DW(QB)) u_div_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(state_q == ST_DIV),
    .num_i($signed(numx_q)), .den_i(d3_q), .done_o(div_done), .quo_o(qx)
  );
  bpp_div #(.NW(NW), .DW(QB)) u_div_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(state_q == ST_DIV),
    .num_i($signed(numy_q)), .den_i(d3_q), .done_o(dvy), .quo_o(qy)
  );
  bpp_div #(.NW(NW), .DW(QB)) u_div_z (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(state_q == ST_DIV),
    .num_i($signed(numz_q)), .den_i(d3_q), .done_o(dvz), .quo_o(qz)
  );

  // ---------------- datapath ----------------
  // pos = S + floor((M + d^3/2) / d^3), M = (E-S)c^3 + 3 dC1 (d-c)^2 c + 3 dC2 (d-c) c^2
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          slot_q     <= slot_i;
          sx_q       <= start_x_i;
          sy_q       <= start_y_i;
          sz_q       <= start_z_i;
          dx_q       <= ctrl_dx_i;
          dy_q       <= ctrl_dy_i;
          dur_q      <= (duration_i == '0) ? DB'(1) : duration_i;
          res_slot_q <= slot_i;
          res_ok_q   <= 1'b0;
          res_ret_q  <= 1'b0;
          res_x_q    <= '0;
          res_y_q    <= '0;
          res_z_q    <= '0;
        end
      end
      ST_SCAN: begin
        if (free_stat.done && free_stat.found) begin
          res_slot_q <= SB'(free_idx);
          res_ok_q   <= 1'b1;
          res_x_q    <= sx_q;
          res_y_q    <= sy_q;
          res_z_q    <= sz_q;
        end else begin
          res_slot_q <= '0;
        end
      end
      ST_LOAD: begin
        {sz_q, sy_q, sx_q, dy_q, dx_q} <= ram_rdata[RW-1:2*DB];
        c_q   <= c_new;
        d_q   <= rd_tot;
        u_q   <= rd_tot - c_new;
        dfx_q <= {end_x_q[CB-1], end_x_q} - {ram_rdata[2*DB+2*OB+CB-1], ram_rdata[2*DB+2*OB +: CB]};
        dfy_q <= {end_y_q[CB-1], end_y_q} - {ram_rdata[2*DB+2*OB+2*CB-1], ram_rdata[2*DB+2*OB+CB +: CB]};
        dfz_q <= {end_z_q[CB-1], end_z_q} - {ram_rdata[RW-1], ram_rdata[RW-CB +: CB]};
      end
      ST_POW1: begin
        c2_q <= c_q * c_q;
        u2_q <= u_q * u_q;
        d2_q <= d_q * d_q;
      end
      ST_POW2: begin
        c3_q  <= c2_q * c_q;
        u2c_q <= u2_q * c_q;
        uc2_q <= c2_q * u_q;
        d3_q  <= d2_q * d_q;
      end
      ST_PROD: begin
        p1x_q <= dfx_q * $signed({1'b0, c3_q});
        p1y_q <= dfy_q * $signed({1'b0, c3_q});
        p1z_q <= dfz_q * $signed({1'b0, c3_q});
        p2x_q <= dx_q * u2c_q;
        p2y_q <= dy_q * u2c_q;
        p3x_q <= K2X * uc2_q;
        p3y_q <= K2Y * uc2_q;
      end
      ST_SUM: begin
        numx_q <= {{(NW-P1W){p1x_q[P1W-1]}}, p1x_q}
                + ({{(NW-P2W){1'b0}}, p2x_q} << 1) + {{(NW-P2W){1'b0}}, p2x_q}
                + ({{(NW-P3W){1'b0}}, p3x_q} << 1) + {{(NW-P3W){1'b0}}, p3x_q}
                + {{(NW-QB){1'b0}}, d3_q >> 1};
        numy_q <= {{(NW-P1W){p1y_q[P1W-1]}}, p1y_q}
                + ({{(NW-P2W){1'b0}}, p2y_q} << 1) + {{(NW-P2W){1'b0}}, p2y_q}
                + ({{(NW-P3W){1'b0}}, p3y_q} << 1) + {{(NW-P3W){1'b0}}, p3y_q}
                + {{(NW-QB){1'b0}}, d3_q >> 1};
        numz_q <= {{(NW-P1W){p1z_q[P1W-1]}}, p1z_q}
                + {{(NW-QB){1'b0}}, d3_q >> 1};
      end
      ST_WAIT: begin
        if (div_done) begin
          res_ok_q  <= 1'b1;
          res_ret_q <= retire;
          res_x_q   <= sat_add(sx_q, qx);
          res_y_q   <= sat_add(sy_q, qy);
          res_z_q   <= sat_add(sz_q, qz);
        end
      end
      default: begin
        res_ok_q <= res_ok_q;
      end
    endcase
  end

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
      out_slot_o  <= '0;
      ok_o        <= 1'b0;
      pos_x_o     <= '0;
      pos_y_o     <= '0;
      pos_z_o     <= '0;
      retired_o   <= 1'b0;
    end else begin
      // in ST_OUT the register is reloaded instead
      if (out_valid_o && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (kind_i == bpp_pkg::KIND_SPAWN) begin
              state_q <= ST_SCAN;
            end else if (tick_ok) begin
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_SCAN: begin
          if (free_stat.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_LOAD: state_q <= ST_POW1;
        ST_POW1: state_q <= ST_POW2;
        ST_POW2: state_q <= ST_PROD;
        ST_PROD: state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_DIV;
        ST_DIV:  state_q <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o <= 1'b1;
            out_slot_o  <= res_slot_q;
            ok_o        <= res_ok_q;
            pos_x_o     <= res_x_q;
            pos_y_o     <= res_y_q;
            pos_z_o     <= res_z_q;
            retired_o   <= res_ret_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_x_q <= '0;
      end_y_q <= '0;
      end_z_q <= '0;
    end else if (cfg_we_i) begin
      case (bpp_pkg::cfg_idx_e'(cfg_idx_i))
        bpp_pkg::CFG_END_X: end_x_q <= cfg_data_i;
        bpp_pkg::CFG_END_Y: end_y_q <= cfg_data_i;
        bpp_pkg::CFG_END_Z: end_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_retire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && retired_o |-> ok_o)
    else $error("retired result without ok");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted item did not make the block busy");

  a_div_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT) && dvy && dvz)
    else $error("divider finished outside wait or lanes out of step");
`endif

endmodule

FILE: rtl/core/bpp_ram.sv
// bpp_ram: generic single-port RAM with registered read data.
// No dependencies.
module bpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bpp_div.sv
// bpp_div: signed-by-unsigned floor divider, restoring, one quotient bit per cycle.
// Depends on nothing but its parameters.
module bpp_div #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic [DW-1:0]        den_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quo_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, done_q, neg_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q, den_q;
  logic [DW:0]     trial, diff;
  logic            ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // negative dividend: floor(n/d) = -((-n + d - 1) / d)
        neg_q  <= num_i[NW-1];
        quo_q  <= num_i[NW-1] ? ({{(NW-DW){1'b0}}, den_i} + ~num_i) : num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= CNTW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[NW-2:0], ge};
        rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: rtl/core/bpp_free.sv
// bpp_free: per-slot active flags and lowest-free-slot search, one chunk per cycle.
// Depends on bpp_pkg.
module bpp_free #(
  parameter int PARTICLES = bpp_pkg::PARTICLES_DEF,
  parameter int SW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bpp_pkg::free_cmd_t     cmd_i,
  input  logic [SW-1:0]          idx_i,
  input  logic [SW-1:0]          look_i,
  output logic                   active_o,
  output bpp_pkg::free_stat_t    stat_o,
  output logic [SW-1:0]          free_idx_o
);

  localparam int CHUNK = bpp_pkg::SCAN_CHUNK;
  localparam int PW    = bpp_pkg::SCAN_POS_BITS;
  localparam int NCH   = (PARTICLES + CHUNK - 1) / CHUNK;
  localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;

  logic [PARTICLES-1:0]   active_q;
  logic [NCH*CHUNK-1:0]   pad;
  logic [CHUNK-1:0]       chunk;
  logic                   busy_q, done_q, found_q, hit;
  logic [CW-1:0]          ptr_q;
  logic [PW-1:0]          pos;
  logic [CW+PW-1:0]       full_idx;
  logic [SW-1:0]          idx_q;

  // slots past the pool read as taken
  always_comb begin
    pad = '1;
    pad[PARTICLES-1:0] = active_q;
  end

  assign chunk = pad[ptr_q*CHUNK +: CHUNK];

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (!chunk[j]) begin
        hit = 1'b1;
        pos = PW'(j);
      end
    end
  end

  assign full_idx = {ptr_q, pos};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      ptr_q    <= '0;
      idx_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.set) begin
        active_q[idx_i] <= 1'b1;
      end
      if (cmd_i.clr) begin
        active_q[idx_i] <= 1'b0;
      end
      if (cmd_i.scan) begin
        busy_q <= 1'b1;
        ptr_q  <= '0;
      end else if (busy_q) begin
        if (hit) begin
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
          found_q <= 1'b1;
          idx_q   <= full_idx[SW-1:0];
        end else if (ptr_q == CW'(NCH - 1)) begin
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
          found_q <= 1'b0;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
    end
  end

  assign active_o     = active_q[look_i];
  assign stat_o.done  = done_q;
  assign stat_o.found = found_q;
  assign free_idx_o   = idx_q;

endmodule

FILE: dv/testbench.sv
// Testbench for bezier_particle_pool: spawn and tick items checked against
// an in-bench fixed-point Bezier predictor. Depends on bpp_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT = 256;
  localparam int CW = 24;

  typedef struct packed {
    logic kind;
    logic [7:0] slot;
    logic signed [CW-1:0] sx, sy, sz;
    logic [14:0] dx, dy;
    logic [7:0] dur;
  } particle_cmd_t;

  typedef struct packed {
    logic [7:0] slot;
    logic ok;
    logic signed [CW-1:0] px, py, pz;
    logic retired;
  } particle_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bpp_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = bpp_pkg::CFG_END_X;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = bpp_pkg::KIND_SPAWN;
  logic [7:0] slot_i = '0;
  logic signed [CW-1:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic [14:0] ctrl_dx_i = '0, ctrl_dy_i = '0;
  logic [7:0] duration_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_slot_o;
  logic ok_o, retired_o;
  logic signed [CW-1:0] pos_x_o, pos_y_o, pos_z_o;

  bezier_particle_pool uut (.*);

  always #5 clk_i = ~clk_i;

  particle_cmd_t pending_cmds[$];
  particle_pos_t expected_pos[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int n_spawn = 0, n_full = 0, n_retire = 0, n_miss = 0, n_checked = 0;

  // predictor state
  logic signed [CW-1:0] end_pt[3];
  bit act[NSLOT];
  logic signed [CW-1:0] sp_x[NSLOT], sp_y[NSLOT], sp_z[NSLOT];
  logic [14:0] off_x[NSLOT], off_y[NSLOT];
  int cnt[NSLOT], tot[NSLOT];

  // stimulus-side view of which slots are live
  bit g_act[NSLOT];
  int g_cnt[NSLOT], g_tot[NSLOT];

  function automatic logic signed [CW-1:0] sat24(longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] curve_pt(longint s, longint c1, longint c2,
                                                   longint e, longint c, longint d);
    longint u, d3, n, q;
    u = d - c;
    d3 = d * d * d;
    n = s * u * u * u + 3 * c1 * u * u * c + 3 * c2 * u * c * c + e * c * c * c;
    n = n + d3 / 2;
    q = n / d3;
    if ((n % d3) != 0 && n < 0) q = q - 1;
    return sat24(q);
  endfunction

  function automatic particle_pos_t advance_pool(particle_cmd_t it);
    particle_pos_t r;
    int i;
    longint c, d;
    r = '0;
    if (it.kind == bpp_pkg::KIND_SPAWN) begin
      for (i = 0; i < NSLOT; i++) if (!act[i]) break;
      if (i >= NSLOT) begin
        n_full++;
        return r;
      end
      sp_x[i] = it.sx; sp_y[i] = it.sy; sp_z[i] = it.sz;
      off_x[i] = it.dx; off_y[i] = it.dy;
      cnt[i] = 0;
      tot[i] = (it.dur == 0) ? 1 : int'(it.dur);
      act[i] = 1;
      r.slot = 8'(i); r.ok = 1;
      r.px = it.sx; r.py = it.sy; r.pz = it.sz;
      n_spawn++;
      return r;
    end
    i = int'(it.slot);
    r.slot = it.slot;
    if (!act[i]) begin
      n_miss++;
      return r;
    end
    if (cnt[i] < tot[i]) cnt[i]++;
    c = cnt[i];
    d = tot[i];
    r.ok = 1;
    r.px = curve_pt(sp_x[i], longint'(sp_x[i]) + off_x[i],
                    longint'(sp_x[i]) + bpp_pkg::C2_DX * 256, end_pt[0], c, d);
    r.py = curve_pt(sp_y[i], longint'(sp_y[i]) + off_y[i],
                    longint'(sp_y[i]) + bpp_pkg::C2_DY * 256, end_pt[1], c, d);
    r.pz = curve_pt(sp_z[i], sp_z[i], sp_z[i], end_pt[2], c, d);
    if (c >= d) begin
      act[i] = 0;
      r.retired = 1;
      n_retire++;
    end
    return r;
  endfunction

  // ---- sender ----
  particle_cmd_t cur;
  int gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_pos.push_back(advance_pool(cur));
      if (!in_valid_i || !in_stall_o) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          gap = $urandom_range(1, 13) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= cur.kind; slot_i <= cur.slot;
          start_x_i <= cur.sx; start_y_i <= cur.sy; start_z_i <= cur.sz;
          ctrl_dx_i <= cur.dx; ctrl_dy_i <= cur.dy; duration_i <= cur.dur;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- receiver and checker ----
  int stall_left = 0;
  particle_pos_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pos.size() == 0) begin
          errors++;
          $display("%0t: unexpected item slot=%0d", $time, out_slot_o);
        end else begin
          want = expected_pos.pop_front();
          n_checked++;
          if (want.slot !== out_slot_o || want.ok !== ok_o || want.px !== pos_x_o ||
              want.py !== pos_y_o || want.pz !== pos_z_o || want.retired !== retired_o) begin
            errors++;
            $display("%0t: mismatch exp slot=%0d ok=%0b x=%0d y=%0d z=%0d ret=%0b",
                     $time, want.slot, want.ok, want.px, want.py, want.pz, want.retired);
            $display("%0t:          got slot=%0d ok=%0b x=%0d y=%0d z=%0d ret=%0b",
                     $time, out_slot_o, ok_o, pos_x_o, pos_y_o, pos_z_o, retired_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 0;
        stall_left = 400;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---- stimulus ----
  task automatic add_spawn(logic signed [CW-1:0] x, y, z, logic [14:0] dx, dy, logic [7:0] dur);
    particle_cmd_t it;
    int i;
    it = '0;
    it.kind = bpp_pkg::KIND_SPAWN; it.slot = 8'($urandom);
    it.sx = x; it.sy = y; it.sz = z; it.dx = dx; it.dy = dy; it.dur = dur;
    pending_cmds.push_back(it);
    for (i = 0; i < NSLOT; i++) if (!g_act[i]) break;
    if (i < NSLOT) begin
      g_act[i] = 1; g_cnt[i] = 0; g_tot[i] = (dur == 0) ? 1 : int'(dur);
    end
  endtask

  task automatic add_tick(int s);
    particle_cmd_t it;
    it = '0;
    it.kind = bpp_pkg::KIND_TICK; it.slot = 8'(s);
    it.sx = CW'($urandom); it.sy = CW'($urandom); it.sz = CW'($urandom);
    it.dx = 15'($urandom); it.dy = 15'($urandom); it.dur = 8'($urandom);
    pending_cmds.push_back(it);
    if (g_act[s]) begin
      g_cnt[s]++;
      if (g_cnt[s] >= g_tot[s]) g_act[s] = 0;
    end
  endtask

  task automatic rand_spawn();
    logic [7:0] d;
    d = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 6));
    add_spawn(CW'($urandom), CW'($urandom), CW'($urandom), 15'($urandom_range(0, 30694)),
              15'($urandom_range(0, 30694)), d);
  endtask

  task automatic tick_live();
    int s, k;
    s = $urandom_range(0, NSLOT - 1);
    for (k = 0; k < NSLOT && !g_act[s]; k++) s = (s + 1) % NSLOT;
    add_tick(s);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid_i || expected_pos.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_end(bpp_pkg::cfg_idx_e idx, logic signed [CW-1:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    end_pt[idx] = v;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) tick_live();
      else if (r < 85) rand_spawn();
      else add_tick($urandom_range(0, 255));
    end
  endtask

  initial begin
    int k;
    end_pt[0] = 0; end_pt[1] = 0; end_pt[2] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_end(bpp_pkg::CFG_END_X, 24'sh7fffff);
    write_end(bpp_pkg::CFG_END_Y, 24'sh800000);
    write_end(bpp_pkg::CFG_END_Z, 24'sh001234);

    // directed: extremes, zero duration, missing slots, saturating C2
    add_tick(0);
    add_tick(255);
    add_spawn(24'sh7fffff, 24'sh7fffff, 24'sh800000, 15'd30694, 15'd30694, 8'd0);
    add_tick(0);
    add_tick(0);
    add_spawn(24'sh800000, 24'sh800000, 24'sh7fffff, 15'd0, 15'd0, 8'd255);
    add_spawn(24'sh7ffff0, 24'sh7fff00, 24'sh000000, 15'd30694, 15'd0, 8'd2);
    add_tick(1);
    add_tick(0);
    add_tick(1);
    add_tick(1);
    add_spawn(24'sh000100, 24'shffff00, 24'sh000000, 15'd16384, 15'd16384, 8'd3);
    for (k = 0; k < 3; k++) add_tick(0);
    add_spawn(24'sh000000, 24'sh000000, 24'sh000000, 15'd1, 15'd1, 8'd1);
    add_tick(0);
    wait_idle();

    // fill the pool under a long output hold, then overflow it
    hold_req = 1;
    for (k = 0; k < NSLOT + 3; k++) rand_spawn();
    random_phase(150);
    wait_idle();

    write_end(bpp_pkg::CFG_END_X, 24'sh800000);
    write_end(bpp_pkg::CFG_END_Y, 24'sh7fffff);
    write_end(bpp_pkg::CFG_END_Z, 24'sh800000);
    random_phase(200);
    wait_idle();

    write_end(bpp_pkg::CFG_END_X, CW'($urandom));
    write_end(bpp_pkg::CFG_END_Y, CW'($urandom));
    write_end(bpp_pkg::CFG_END_Z, 24'sh7fffff);
    random_phase(150);
    wait_idle();

    quiet = 1;
    random_phase(150);
    wait_idle();
    repeat (200) @(posedge clk_i);

    if (expected_pos.size() != 0) errors++;
    $display("run: %0d results checked, %0d spawns, %0d full-pool rejects,", n_checked,
             n_spawn, n_full);
    $display("     %0d retirements, %0d ticks on free slots, end point swept", n_retire, n_miss);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

endmodule
